>>> rtl/apd_pkg.sv
package apd_pkg;

  localparam int DEF_MAX_DELAY   = 1024;
  localparam int DEF_STAGE_COUNT = 3;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int LINE_COUNT     = 3;
  localparam int LINE_IDX_BITS  = 2;
  localparam int GAIN_BITS      = 15;
  localparam int DELAY_BITS     = 11;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 15;
  localparam int ROUND_SHIFT    = 15;

  localparam logic [GAIN_BITS-1:0] GAIN_LIMIT = 15'd29491;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 15'd0;

  localparam logic [DELAY_BITS-1:0] DELAY_RESET [LINE_COUNT] = '{11'd53, 11'd79, 11'd115};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GAIN   = 2'd0,
    REG_DELAY1 = 2'd1,
    REG_DELAY2 = 2'd2,
    REG_DELAY3 = 2'd3
  } cfg_reg_t;

  // one strobe per datapath step, at most one set in a cycle
  typedef struct packed {
    logic load_in;
    logic mul_b;
    logic sum_v;
    logic mul_v;
    logic sum_y;
  } dp_ctrl_t;

endpackage

>>> rtl/apd_datapath.sv
module apd_datapath #(
  parameter int SAMPLE_BITS = apd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  apd_pkg::dp_ctrl_t                   ctrl,
  input  logic [apd_pkg::GAIN_BITS-1:0]       gain,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  input  logic signed [SAMPLE_BITS-1:0]       tap,
  input  logic                                tap_valid,
  output logic signed [SAMPLE_BITS-1:0]       line_value,
  output logic signed [SAMPLE_BITS-1:0]       stage_value
);
  import apd_pkg::*;

  localparam int PB = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int RB = PB - ROUND_SHIFT;
  localparam int WB = RB + 1;
  localparam logic signed [PB-1:0] RND_HALF = PB'(1) <<< (ROUND_SHIFT - 1);

  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic signed [SAMPLE_BITS-1:0] b_reg;
  logic signed [SAMPLE_BITS-1:0] v_reg;
  logic signed [PB-1:0]          prod;

  logic [GAIN_BITS-1:0]          g_used;
  logic signed [GAIN_BITS:0]     g_s;
  logic signed [SAMPLE_BITS-1:0] b_sel;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [PB-1:0]          prod_next;
  logic signed [PB-1:0]          prod_pos_r;
  logic signed [PB-1:0]          prod_neg_r;
  logic signed [RB-1:0]          rnd_pos;
  logic signed [RB-1:0]          rnd_neg;
  logic signed [WB-1:0]          v_wide;
  logic signed [WB-1:0]          y_wide;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_fn(input logic signed [WB-1:0] a);
    logic [WB-SAMPLE_BITS:0] top;
    top = a[WB-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return a[SAMPLE_BITS-1:0];
    end else if (a[WB-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  assign g_used = (gain > GAIN_LIMIT) ? GAIN_LIMIT : gain;
  assign g_s    = {1'b0, g_used};
  // an entry not yet written since reset reads as zero
  assign b_sel  = tap_valid ? tap : '0;
  assign mul_a  = ctrl.mul_v ? v_reg : b_sel;

  always_comb begin
    prod_next  = g_s * mul_a;
    prod_pos_r = prod + RND_HALF;
    prod_neg_r = RND_HALF - prod;
    // arithmetic shift by part-select, rounds half toward plus infinity
    rnd_pos    = $signed(prod_pos_r[PB-1:ROUND_SHIFT]);
    rnd_neg    = $signed(prod_neg_r[PB-1:ROUND_SHIFT]);
    v_wide     = {{(WB-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg} + {rnd_pos[RB-1], rnd_pos};
    y_wide     = {{(WB-SAMPLE_BITS){b_reg[SAMPLE_BITS-1]}}, b_reg} + {rnd_neg[RB-1], rnd_neg};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      x_reg <= sample_in;
    end else if (ctrl.sum_y) begin
      x_reg <= sat_fn(y_wide);
    end
    if (ctrl.mul_b) begin
      b_reg <= b_sel;
    end
    if (ctrl.mul_b || ctrl.mul_v) begin
      prod <= prod_next;
    end
    if (ctrl.sum_v) begin
      v_reg <= sat_fn(v_wide);
    end
  end

  assign line_value  = v_reg;
  assign stage_value = x_reg;

endmodule

>>> rtl/allpass_diffuser_chain.sv
// Chain of Schroeder allpass stages (three at the default setting) over signed Q1.23 samples,
// gain g unsigned Q0.15 held at 0.9 at most. All delay lines sit in one synchronous memory,
// one region per stage, sharing a write position that moves one entry per sample; a fill
// count stands for the cleared lines after reset, so there is no clearing pass. Each stage
// steps through memory read, then g*b, v, g*v and y through one shared multiplier. An item
// is held from its transfer in, through all stages, until its result enters the output register;
// that waits while the register still holds a stalled result. No new sample is taken before
// then (in_stall is high outside idle); the next can be taken the cycle after. The output
// register lets the next item start while a result still waits. Configuration writes are
// taken in any cycle (cfg_ready is tied high); change them only while the chain is idle.
module allpass_diffuser_chain #(
  parameter int MAX_DELAY   = apd_pkg::DEF_MAX_DELAY,
  parameter int STAGE_COUNT = apd_pkg::DEF_STAGE_COUNT,
  parameter int SAMPLE_BITS = apd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          sample_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]          sample_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [apd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [apd_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import apd_pkg::*;

  localparam int NST   = (STAGE_COUNT < LINE_COUNT) ? STAGE_COUNT : LINE_COUNT;
  localparam int PW    = $clog2(MAX_DELAY);
  localparam int SW    = (NST > 1) ? $clog2(NST) : 1;
  localparam int DEPTH = NST * (2 ** PW);
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = PW + 1;
  localparam int CW    = (DELAY_BITS > DW) ? DELAY_BITS : DW;

  localparam logic [SW-1:0] LAST_STAGE = SW'(NST - 1);
  localparam logic [DW-1:0] MAX_D      = DW'(MAX_DELAY);
  localparam logic [PW-1:0] LAST_POS   = PW'(MAX_DELAY - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_MULB = 7'b0000100,
    S_SUMV = 7'b0001000,
    S_MULV = 7'b0010000,
    S_SUMY = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [SW-1:0]                 stage;
  logic [PW-1:0]                 wp;
  logic [DW-1:0]                 fill;
  logic [GAIN_BITS-1:0]          gain;
  logic [DELAY_BITS-1:0]         delay_reg [LINE_COUNT];
  logic                          hit;
  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data;

  logic [DELAY_BITS-1:0]         delay_sel;
  logic [CW-1:0]                 delay_wide;
  logic [DW-1:0]                 d_used;
  logic [DW:0]                   rd_tmp;
  logic [PW-1:0]                 rd_pos;
  logic [AW-1:0]                 raddr;
  logic [AW-1:0]                 waddr;
  logic                          mem_we;
  logic                          out_free;
  logic                          last_step;
  dp_ctrl_t                      ctrl;
  logic signed [SAMPLE_BITS-1:0] line_value;
  logic signed [SAMPLE_BITS-1:0] stage_value;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign last_step = (state == S_SUMY) && (stage == LAST_STAGE);

  // tap address: write position minus the clamped delay, modulo the line length
  always_comb begin
    delay_sel  = delay_reg[LINE_IDX_BITS'(stage)];
    delay_wide = CW'(delay_sel);
    if (delay_sel == '0) begin
      d_used = DW'(1);
    end else if (delay_wide > CW'(MAX_DELAY)) begin
      d_used = MAX_D;
    end else begin
      d_used = DW'(delay_wide);
    end
    rd_tmp = (DW+1)'(wp) + (DW+1)'(MAX_DELAY) - (DW+1)'(d_used);
    if (rd_tmp >= (DW+1)'(MAX_DELAY)) begin
      rd_pos = PW'(rd_tmp - (DW+1)'(MAX_DELAY));
    end else begin
      rd_pos = PW'(rd_tmp);
    end
    raddr = AW'({stage, rd_pos});
    waddr = AW'({stage, wp});
  end

  assign mem_we = (state == S_MULV);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= line_value;
    end
    rd_data <= mem[raddr];
  end

  always_comb begin
    ctrl.load_in = (state == S_IDLE) && in_valid;
    ctrl.mul_b   = (state == S_MULB);
    ctrl.sum_v   = (state == S_SUMV);
    ctrl.mul_v   = (state == S_MULV);
    ctrl.sum_y   = (state == S_SUMY);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: state_next = S_MULB;
      S_MULB: state_next = S_SUMV;
      S_SUMV: state_next = S_MULV;
      S_MULV: state_next = S_SUMY;
      S_SUMY: state_next = (stage == LAST_STAGE) ? S_DONE : S_READ;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stage     <= '0;
      wp        <= '0;
      fill      <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load_in) begin
        stage <= '0;
      end else if (ctrl.sum_y && (stage != LAST_STAGE)) begin
        stage <= stage + SW'(1);
      end
      if (state == S_READ) begin
        // the tap entry was written since reset once the fill count reaches the delay
        hit <= (fill >= d_used);
      end
      if (last_step) begin
        wp <= (wp == LAST_POS) ? '0 : wp + PW'(1);
        if (fill != MAX_D) fill <= fill + DW'(1);
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      sample_out <= stage_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
      for (int i = 0; i < LINE_COUNT; i++) begin
        delay_reg[i] <= DELAY_RESET[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN:   gain         <= cfg_data[GAIN_BITS-1:0];
        REG_DELAY1: delay_reg[0] <= cfg_data[DELAY_BITS-1:0];
        REG_DELAY2: delay_reg[1] <= cfg_data[DELAY_BITS-1:0];
        REG_DELAY3: delay_reg[2] <= cfg_data[DELAY_BITS-1:0];
        default:    gain         <= gain;
      endcase
    end
  end

  apd_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .ctrl       (ctrl),
    .gain       (gain),
    .sample_in  (sample_in),
    .tap        (rd_data),
    .tap_valid  (hit),
    .line_value (line_value),
    .stage_value(stage_value)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= MAX_D)
    else $error("fill count beyond line length");

  a_stage_bound: assert property (@(posedge clk) disable iff (rst) stage <= LAST_STAGE)
    else $error("stage index beyond last stage");

  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    (wp != $past(wp)) |-> $past(last_step))
    else $error("write position moved outside the end of an item");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_free) |=> (out_valid && (sample_out == $past(stage_value))))
    else $error("finished result not loaded into output register");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import apd_pkg::*;

  localparam int MAX_DELAY = DEF_MAX_DELAY;
  localparam int SB = DEF_SAMPLE_BITS;
  localparam int STAGES = (DEF_STAGE_COUNT < LINE_COUNT) ? DEF_STAGE_COUNT : LINE_COUNT;
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam int STUCK_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // mirror of the chain state
  logic [GAIN_BITS-1:0] model_gain;
  logic [DELAY_BITS-1:0] model_delay [LINE_COUNT];
  logic signed [SB-1:0] model_line [LINE_COUNT][MAX_DELAY];
  logic [$clog2(MAX_DELAY)-1:0] model_wpos;

  logic signed [SB-1:0] pending_diffused [$];
  int mismatch_count = 0;
  int stuck_cycles = 0;
  bit calm = 1'b0;

  allpass_diffuser_chain dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor((p + 2^14) / 2^15)
  function automatic longint round_half_up(longint p);
    return (p + 64'sd16384) >>> ROUND_SHIFT;
  endfunction

  function automatic longint clip_sample(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  function automatic logic signed [SB-1:0] diffuse_sample(logic signed [SB-1:0] x_in);
    longint x, b, v, y, g;
    int d, rd, s;
    g = (model_gain > GAIN_LIMIT) ? longint'(GAIN_LIMIT) : longint'(model_gain);
    x = longint'(x_in);
    for (s = 0; s < STAGES; s++) begin
      d = int'(model_delay[s]);
      if (d < 1) d = 1;
      if (d > MAX_DELAY) d = MAX_DELAY;
      rd = (int'(model_wpos) + MAX_DELAY - d) % MAX_DELAY;
      b = longint'(model_line[s][rd]);
      v = clip_sample(x + round_half_up(g * b));
      y = clip_sample(round_half_up(-(g * v)) + b);
      model_line[s][model_wpos] = SB'(v);
      x = y;
    end
    model_wpos = model_wpos + 1'b1;
    return SB'(x);
  endfunction

  // predictor and checker, both on the rising edge
  always @(posedge clk) begin
    logic signed [SB-1:0] want;
    if (rst) begin
      model_gain = GAIN_RESET;
      model_wpos = '0;
      for (int s = 0; s < LINE_COUNT; s++) begin
        model_delay[s] = DELAY_RESET[s];
        for (int i = 0; i < MAX_DELAY; i++) model_line[s][i] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_GAIN:   model_gain = cfg_data[GAIN_BITS-1:0];
          REG_DELAY1: model_delay[0] = cfg_data[DELAY_BITS-1:0];
          REG_DELAY2: model_delay[1] = cfg_data[DELAY_BITS-1:0];
          REG_DELAY3: model_delay[2] = cfg_data[DELAY_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pending_diffused.push_back(diffuse_sample(sample_in));
      if (out_valid && !out_stall) begin
        if (pending_diffused.size() == 0) begin
          mismatch_count++;
          $display("%0t: sample_out with nothing pending, expected none, actual %0d",
                   $time, sample_out);
        end else begin
          want = pending_diffused.pop_front();
          if (sample_out !== want) begin
            mismatch_count++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, sample_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 14);
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // leaves in_valid high so back-to-back transfers need no drop
  task automatic send_sample(logic signed [SB-1:0] value);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop sending and let the chain drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_diffused.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(9))
      0: return SB'(SAMPLE_MAX);
      1: return SB'(SAMPLE_MIN);
      2: return SB'($signed($urandom_range(512)) - 256);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return GAIN_LIMIT;
      2: return CFG_DATA_BITS'($urandom_range(32767, 29492));
      default: return CFG_DATA_BITS'($urandom_range(32767));
    endcase
  endfunction

  // upper data bits are don't-care for the delay registers, so fill them randomly
  function automatic logic [CFG_DATA_BITS-1:0] pick_delay();
    logic [DELAY_BITS-1:0] d;
    case ($urandom_range(9))
      0: d = '0;
      1: d = DELAY_BITS'(MAX_DELAY);
      2: d = DELAY_BITS'($urandom_range(2047, MAX_DELAY + 1));
      3, 4: d = DELAY_BITS'($urandom_range(600, 100));
      default: d = DELAY_BITS'($urandom_range(16, 1));
    endcase
    return {(CFG_DATA_BITS - DELAY_BITS)'($urandom), d};
  endfunction

  task automatic run_phase(int count, bit pause_mid);
    write_reg(REG_GAIN, pick_gain());
    write_reg(REG_DELAY1, pick_delay());
    write_reg(REG_DELAY2, pick_delay());
    write_reg(REG_DELAY3, pick_delay());
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_diffused.size() != 0) @(negedge clk);
      end
      send_sample(pick_sample());
    end
    settle();
  endtask

  // gain zero after reset: a pure delay through the default line lengths
  task automatic test_default_registers();
    send_sample(SB'(SAMPLE_MAX));
    send_sample(SB'(SAMPLE_MIN));
    send_sample('0);
    send_sample(SB'(-1));
    send_sample(SB'(1));
    send_sample(SB'(24'h555555));
    settle();
  endtask

  // gain above 0.9, zero and oversized delays, saturation of v and y
  task automatic test_saturation_and_clamps();
    write_reg(REG_GAIN, 15'h7FFF);
    write_reg(REG_DELAY1, 15'h7800);
    write_reg(REG_DELAY2, 15'h0001);
    write_reg(REG_DELAY3, 15'h7FFF);
    repeat (4) send_sample(SB'(SAMPLE_MAX));
    repeat (4) send_sample(SB'(SAMPLE_MIN));
    send_sample(SB'(24'hAAAAAA));
    send_sample('0);
    send_sample(SB'(SAMPLE_MAX));
    send_sample('0);
    settle();
    write_reg(REG_GAIN, GAIN_LIMIT);
    write_reg(REG_DELAY1, 15'(MAX_DELAY));
    write_reg(REG_DELAY2, 15'(MAX_DELAY));
    write_reg(REG_DELAY3, 15'(MAX_DELAY));
    send_sample(SB'(SAMPLE_MIN));
    send_sample(SB'(SAMPLE_MAX));
    send_sample(SB'(-1));
    send_sample(SB'(1));
    settle();
  endtask

  task automatic test_random_settings();
    repeat (3) run_phase(106, 1'b0);
  endtask

  task automatic test_sender_pause();
    run_phase(106, 1'b1);
  endtask

  task automatic test_calm_stream();
    calm = 1'b1;
    run_phase(106, 1'b0);
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_registers();
    test_saturation_and_clamps();
    test_random_settings();
    test_sender_pause();
    test_calm_stream();
    settle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_diffused.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
